@@ rtl/three_band_one_pole_splitter_macros.svh @@
// assertion macros for the three band splitter
// uses clk and rst_n of the including module; no other dependencies
`ifndef THREE_BAND_ONE_POLE_SPLITTER_MACROS_SVH
`define THREE_BAND_ONE_POLE_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is held
`define TBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define TBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TBS_ASSERT(lbl, prop, msg)
`define TBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/tbs_pkg.sv @@
// shared types, constants and saturation helper for the three band splitter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tbs_pkg;

  localparam int CHANNELS    = 2;
  localparam int CH_W        = 1;
  localparam int SAMPLE_W    = 24;
  localparam int GUARD       = 7;
  localparam int COEF_W      = 16;
  localparam int STATE_W     = 32;
  // differences carry two bits of headroom over the state
  localparam int DIFF_W      = STATE_W + 2;
  localparam int PROD_W      = DIFF_W + COEF_W + 1;
  localparam int WIDE_W      = DIFF_W - GUARD;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COEF_W-1:0] ALPHA_LOW_RESET  = 16'd1526;
  localparam logic [COEF_W-1:0] ALPHA_HIGH_RESET = 16'd24088;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;

  localparam logic signed [WIDE_W-1:0] SMAX_W = WIDE_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] SMIN_W = WIDE_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

  // operand select of the shared multiplier
  typedef enum logic [1:0] {
    MUL_BASS,
    MUL_TOP,
    MUL_MID
  } mul_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_b;
    logic     upd_t;
    logic     hp_en;
    logic     upd_m;
    logic     band_bt;
    logic     band_v_wb;
    logic     out_load;
  } tbs_cmd_t;

  // clamp a wide value to full scale
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [SAMPLE_W-1:0] r;
    if (v > SMAX_W) begin
      r = SMAX_W[SAMPLE_W-1:0];
    end else if (v < SMIN_W) begin
      r = SMIN_W[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/three_band_one_pole_splitter.sv @@
// three band one-pole splitter top level: controller plus datapath
// depends on tbs_pkg, tbs_ctrl and tbs_datapath
//
// channel  | handshake               | payload
// in       | in_valid / in_ready     | in_sample_in, in_channel, in_first_of_buffer
// out      | out_valid / out_ready   | out_bass_out .. out_music_out, out_channel_out
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one item runs to its output step before the next input transfer is possible (in_ready only when idle):
// three filter updates share one multiplier and run in dependent steps
// reset is synchronous; all filter state and coefficients return to defaults at once
// results sit in an output register; a stalled output holds the block in its last step
// configuration writes are always taken (cfg_ready is high)
`timescale 1ns / 1ps
`default_nettype none

module three_band_one_pole_splitter (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [tbs_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  wire logic [tbs_pkg::CH_W-1:0]              in_channel,
  input  wire logic                                  in_first_of_buffer,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [tbs_pkg::SAMPLE_W-1:0]        out_bass_out,
  output logic signed [tbs_pkg::SAMPLE_W-1:0]        out_vocals_out,
  output logic signed [tbs_pkg::SAMPLE_W-1:0]        out_drums_out,
  output logic signed [tbs_pkg::SAMPLE_W-1:0]        out_music_out,
  output logic [tbs_pkg::CH_W-1:0]                   out_channel_out,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tbs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [tbs_pkg::COEF_W-1:0]            cfg_data
);

  tbs_pkg::tbs_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // sequencer
  tbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and storage
  tbs_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_sample_in       (in_sample_in),
    .in_channel         (in_channel),
    .in_first_of_buffer (in_first_of_buffer),
    .out_bass_out       (out_bass_out),
    .out_vocals_out     (out_vocals_out),
    .out_drums_out      (out_drums_out),
    .out_music_out      (out_music_out),
    .out_channel_out    (out_channel_out)
  );

endmodule

`default_nettype wire

@@ rtl/tbs_datapath.sv @@
// datapath: coefficients, per-channel filter state, shared multiplier, band outputs
// depends on tbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module tbs_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire tbs_pkg::tbs_cmd_t                     cmd,
  input  wire logic                                  cfg_we,
  input  wire logic [tbs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [tbs_pkg::COEF_W-1:0]            cfg_data,
  input  wire logic signed [tbs_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  wire logic [tbs_pkg::CH_W-1:0]              in_channel,
  input  wire logic                                  in_first_of_buffer,
  output logic signed [tbs_pkg::SAMPLE_W-1:0]        out_bass_out,
  output logic signed [tbs_pkg::SAMPLE_W-1:0]        out_vocals_out,
  output logic signed [tbs_pkg::SAMPLE_W-1:0]        out_drums_out,
  output logic signed [tbs_pkg::SAMPLE_W-1:0]        out_music_out,
  output logic [tbs_pkg::CH_W-1:0]                   out_channel_out
);

  localparam int SW = tbs_pkg::STATE_W;
  localparam int DW = tbs_pkg::DIFF_W;
  localparam int GD = tbs_pkg::GUARD;
  localparam int WW = tbs_pkg::WIDE_W;

  logic [tbs_pkg::COEF_W-1:0] alpha_low_r;
  logic [tbs_pkg::COEF_W-1:0] alpha_high_r;

  logic signed [SW-1:0] bass_lp_r [tbs_pkg::CHANNELS];
  logic signed [SW-1:0] mid_lp_r  [tbs_pkg::CHANNELS];
  logic signed [SW-1:0] top_lp_r  [tbs_pkg::CHANNELS];

  // per-item working registers
  logic signed [tbs_pkg::SAMPLE_W-1:0] x_r;
  logic signed [SW-1:0]                xs_r;
  logic [tbs_pkg::CH_W-1:0]            ch_r;
  logic signed [SW-1:0]                sb_r;
  logic signed [SW-1:0]                sm_r;
  logic signed [SW-1:0]                st_r;
  logic signed [DW-1:0]                hp_r;
  logic signed [tbs_pkg::PROD_W-1:0]   prod_r;
  logic signed [tbs_pkg::SAMPLE_W-1:0] bass_r;
  logic signed [tbs_pkg::SAMPLE_W-1:0] vocals_r;
  logic signed [tbs_pkg::SAMPLE_W-1:0] drums_r;

  logic signed [DW-1:0]                mul_a;
  logic signed [DW-1:0]                mul_b;
  logic [tbs_pkg::COEF_W-1:0]          mul_coef;
  logic signed [tbs_pkg::COEF_W:0]     coef_s;
  logic signed [DW-1:0]                diff;
  logic signed [tbs_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [tbs_pkg::PROD_W-1:0]   step_full;
  logic signed [SW-1:0]                step;
  logic signed [DW-1:0]                xs_ext;
  logic signed [DW-1:0]                drums_diff;
  logic signed [DW-1:0]                sb_ext;
  logic signed [DW-1:0]                sm_ext;
  logic signed [WW-1:0]                music_wide;
  logic signed [SW-1:0]                xs_nxt;

  // sample scaled onto the state grid
  assign xs_nxt = {{(SW - tbs_pkg::SAMPLE_W - GD){in_sample_in[tbs_pkg::SAMPLE_W-1]}},
                   in_sample_in, {GD{1'b0}}};

  assign xs_ext = DW'(xs_r);
  assign sb_ext = DW'(sb_r);
  assign sm_ext = DW'(sm_r);
  assign drums_diff = xs_ext - DW'(st_r);

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      tbs_pkg::MUL_BASS: begin
        mul_a    = xs_ext;
        mul_b    = sb_ext;
        mul_coef = alpha_low_r;
      end
      tbs_pkg::MUL_TOP: begin
        mul_a    = xs_ext;
        mul_b    = DW'(st_r);
        mul_coef = alpha_high_r;
      end
      tbs_pkg::MUL_MID: begin
        mul_a    = hp_r;
        mul_b    = sm_ext;
        mul_coef = alpha_high_r;
      end
      default: begin
        mul_a    = xs_ext;
        mul_b    = sb_ext;
        mul_coef = alpha_low_r;
      end
    endcase
  end

  assign diff      = mul_a - mul_b;
  assign coef_s    = {1'b0, mul_coef};
  assign prod_nxt  = diff * coef_s;
  // floor of product over 2^16, kept to state width
  assign step_full = prod_r >>> tbs_pkg::COEF_W;
  assign step      = step_full[SW-1:0];

  // music residual from the three saturated bands
  assign music_wide = WW'(x_r) - WW'(bass_r) - WW'(vocals_r) - WW'(drums_r);

  // coefficient registers and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r  <= tbs_pkg::ALPHA_LOW_RESET;
      alpha_high_r <= tbs_pkg::ALPHA_HIGH_RESET;
      for (int i = 0; i < tbs_pkg::CHANNELS; i++) begin
        bass_lp_r[i] <= '0;
        mid_lp_r[i]  <= '0;
        top_lp_r[i]  <= '0;
      end
    end else begin
      if (cfg_we && cfg_index == tbs_pkg::REG_ALPHA_LOW) begin
        alpha_low_r <= cfg_data;
      end
      if (cfg_we && cfg_index == tbs_pkg::REG_ALPHA_HIGH) begin
        alpha_high_r <= cfg_data;
      end
      if (cmd.band_v_wb) begin
        bass_lp_r[ch_r] <= sb_r;
        mid_lp_r[ch_r]  <= sm_r;
        top_lp_r[ch_r]  <= st_r;
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r  <= in_sample_in;
      xs_r <= xs_nxt;
      ch_r <= in_channel;
      sb_r <= in_first_of_buffer ? '0 : bass_lp_r[in_channel];
      sm_r <= in_first_of_buffer ? '0 : mid_lp_r[in_channel];
      st_r <= in_first_of_buffer ? '0 : top_lp_r[in_channel];
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.upd_b) begin
      sb_r <= sb_r + step;
    end
    if (cmd.upd_t) begin
      st_r <= st_r + step;
    end
    if (cmd.upd_m) begin
      sm_r <= sm_r + step;
    end
    if (cmd.hp_en) begin
      hp_r <= xs_ext - sb_ext;
    end
    if (cmd.band_bt) begin
      bass_r  <= tbs_pkg::sat_sample(sb_ext[DW-1:GD]);
      drums_r <= tbs_pkg::sat_sample(drums_diff[DW-1:GD]);
    end
    if (cmd.band_v_wb) begin
      vocals_r <= tbs_pkg::sat_sample(sm_ext[DW-1:GD]);
    end
    if (cmd.out_load) begin
      out_bass_out    <= bass_r;
      out_vocals_out  <= vocals_r;
      out_drums_out   <= drums_r;
      out_music_out   <= tbs_pkg::sat_sample(music_wide);
      out_channel_out <= ch_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tbs_ctrl.sv @@
// controller: sequences the three filter updates, input and output handshakes
// depends on tbs_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "three_band_one_pole_splitter_macros.svh"

module tbs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tbs_pkg::tbs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MB,
    S_MT,
    S_MM,
    S_MH,
    S_UM,
    S_BND,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // command decode and next state
  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = tbs_pkg::MUL_BASS;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_MB;
        end
      end
      S_MB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tbs_pkg::MUL_BASS;
        state_nxt   = S_MT;
      end
      S_MT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tbs_pkg::MUL_TOP;
        cmd.upd_b   = 1'b1;
        state_nxt   = S_MM;
      end
      S_MM: begin
        cmd.upd_t = 1'b1;
        cmd.hp_en = 1'b1;
        state_nxt = S_MH;
      end
      S_MH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tbs_pkg::MUL_MID;
        state_nxt   = S_UM;
      end
      S_UM: begin
        cmd.upd_m   = 1'b1;
        cmd.band_bt = 1'b1;
        state_nxt   = S_BND;
      end
      S_BND: begin
        cmd.band_v_wb = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TBS_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state_r == S_MB), "accept did not start filtering")
  `TBS_ASSERT(a_valid_from_out, $rose(out_valid_r) |-> $past(state_r == S_OUT), "result raised outside output step")
  `TBS_ASSERT(a_single_update, $onehot0({cmd.upd_b, cmd.upd_t, cmd.upd_m}), "two state updates in one cycle")
  `TBS_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_r || out_ready), "output register overwritten")
  `TBS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset did not idle")

endmodule

`default_nettype wire
